// ----- sv/utf8_stream_sanitizer_unit_macros.svh -----
// Assertion macros used by the checker of this block.
`ifndef UTF8_STREAM_SANITIZER_UNIT_MACROS_SVH
`define UTF8_STREAM_SANITIZER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define U8S_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define U8S_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well.
`define U8S_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/utf8san_pkg.sv -----
`timescale 1ns / 1ps

package utf8san_pkg;

   typedef logic [7:0] byte_type;

   localparam byte_type ASCII_LIMIT = 8'h80;
   localparam byte_type CONT_LO     = 8'h80;
   localparam byte_type CONT_HI     = 8'hBF;
   localparam byte_type LEAD2_LO    = 8'hC2;
   localparam byte_type LEAD2_HI    = 8'hDF;
   localparam byte_type LEAD3_LO    = 8'hE0;
   localparam byte_type LEAD3_HI    = 8'hEF;
   localparam byte_type LEAD4_LO    = 8'hF0;
   localparam byte_type LEAD4_HI    = 8'hF4;

   localparam byte_type REPL_BACKSLASH = 8'h5C;
   localparam byte_type CHAR_LOWER_U   = 8'h75;
   localparam byte_type CHAR_LOWER_F   = 8'h66;
   localparam byte_type CHAR_LOWER_D   = 8'h64;

   localparam int       MAX_UNITS  = 4;
   localparam int       UNIT_IDX_W = 2;
   localparam int       UNIT_CNT_W = 3;
   localparam int       SUB_W      = 3;
   localparam logic [SUB_W-1:0] REPL_LAST = 3'd5;

   typedef struct packed {
      logic     is_repl;
      byte_type value;
   } unit_type;

   function automatic byte_type repl_char(input logic [SUB_W-1:0] idx);
      byte_type ch;
      case (idx)
         3'd0:    ch = REPL_BACKSLASH;
         3'd1:    ch = CHAR_LOWER_U;
         3'd2:    ch = CHAR_LOWER_F;
         3'd3:    ch = CHAR_LOWER_F;
         3'd4:    ch = CHAR_LOWER_F;
         3'd5:    ch = CHAR_LOWER_D;
         default: ch = CHAR_LOWER_D;
      endcase
      return ch;
   endfunction

endpackage

// ----- sv/utf8san_chan_if.sv -----
`timescale 1ns / 1ps

interface utf8san_req_if;
   import utf8san_pkg::*;

   logic     valid;
   logic     ready;
   byte_type in_byte;
   logic     text_end;

   modport source (output valid, in_byte, text_end, input ready);
   modport sink   (input valid, in_byte, text_end, output ready);
endinterface

interface utf8san_rsp_if;
   import utf8san_pkg::*;

   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     run_last;
   logic     text_done;

   modport source (output valid, out_byte, run_last, text_done, input ready);
   modport sink   (input valid, out_byte, run_last, text_done, output ready);
endinterface

// ----- sv/utf8_stream_sanitizer_unit.sv -----
// An item is taken into the job register, and its results pass on through the result register.
// Throughput: one result per cycle while the output does not stall; an item has 0 to 24
// results and holds the emitter until its last one, so one-result items stream at one per cycle.
// The emitter steps through up to four units, a replacement unit being six bytes.
// Reset (synchronous, active high) drops any pending sequence and empties both
// the job register and the result register.
`timescale 1ns / 1ps

module utf8_stream_sanitizer_unit (
   input  logic          clock,
   input  logic          reset,
   utf8san_req_if.sink   req_chan,
   utf8san_rsp_if.source rsp_chan
);
   import utf8san_pkg::*;

   // sequence state
   byte_type lead_ff, lead_in;
   logic [1:0] need_ff, need_in;
   logic [1:0] count_ff, count_in;
   byte_type cont_ff [2];
   logic cont_we;

   // job register
   logic job_valid_ff;
   unit_type job_units_ff [MAX_UNITS];
   logic [UNIT_CNT_W-1:0] job_count_ff;
   logic job_end_ff;
   logic [UNIT_IDX_W-1:0] unit_idx_ff;
   logic [SUB_W-1:0] sub_ff;

   // result register
   logic rsp_valid_ff;
   byte_type rsp_byte_ff;
   logic rsp_run_last_ff;
   logic rsp_done_ff;

   // plan
   unit_type plan_units [MAX_UNITS];
   logic [UNIT_CNT_W-1:0] plan_n;

   byte_type b;
   logic text_end;
   logic pending, is_cont, is_ascii;
   logic [1:0] lead_need;

   unit_type cur_unit;
   byte_type cur_byte;
   logic unit_last, job_last, rsp_free, emit, accept;

   assign b        = req_chan.in_byte;
   assign text_end = req_chan.text_end;
   assign pending  = (need_ff != 2'd0);
   assign is_cont  = b inside {[CONT_LO:CONT_HI]};
   assign is_ascii = (b < ASCII_LIMIT);

   always_comb begin
      if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
         lead_need = 2'd1;
      end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
         lead_need = 2'd2;
      end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
         lead_need = 2'd3;
      end else begin
         lead_need = 2'd0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_UNITS; i++) begin
         plan_units[i] = '0;
      end
      plan_n   = '0;
      lead_in  = lead_ff;
      need_in  = need_ff;
      count_in = count_ff;
      cont_we  = 1'b0;
      if (pending && is_cont &&
          (({1'b0, count_ff} + 3'd1) >= {1'b0, need_ff})) begin
         plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b0, value: lead_ff};
         plan_n = plan_n + 3'd1;
         if (count_ff >= 2'd1) begin
            plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b0, value: cont_ff[0]};
            plan_n = plan_n + 3'd1;
         end
         if (count_ff >= 2'd2) begin
            plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b0, value: cont_ff[1]};
            plan_n = plan_n + 3'd1;
         end
         plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b0, value: b};
         plan_n   = plan_n + 3'd1;
         lead_in  = '0;
         need_in  = '0;
         count_in = '0;
      end else if (pending && is_cont) begin
         cont_we  = 1'b1;
         count_in = count_ff + 2'd1;
         if (text_end) begin
            plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b1, value: '0};
            plan_n = plan_n + 3'd1;
            if (count_in >= 2'd1) begin
               plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b1, value: '0};
               plan_n = plan_n + 3'd1;
            end
            if (count_in >= 2'd2) begin
               plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b1, value: '0};
               plan_n = plan_n + 3'd1;
            end
            lead_in  = '0;
            need_in  = '0;
            count_in = '0;
         end
      end else begin
         if (pending) begin
            plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b1, value: '0};
            plan_n = plan_n + 3'd1;
            if (count_ff >= 2'd1) begin
               plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b1, value: '0};
               plan_n = plan_n + 3'd1;
            end
            if (count_ff >= 2'd2) begin
               plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b1, value: '0};
               plan_n = plan_n + 3'd1;
            end
            lead_in  = '0;
            need_in  = '0;
            count_in = '0;
         end
         if (is_ascii) begin
            plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b0, value: b};
            plan_n = plan_n + 3'd1;
         end else if (lead_need != 2'd0 && !text_end) begin
            lead_in  = b;
            need_in  = lead_need;
            count_in = '0;
         end else begin
            plan_units[plan_n[UNIT_IDX_W-1:0]] = '{is_repl: 1'b1, value: '0};
            plan_n = plan_n + 3'd1;
         end
      end
   end

   assign cur_unit  = job_units_ff[unit_idx_ff];
   assign cur_byte  = cur_unit.is_repl ? repl_char(sub_ff) : cur_unit.value;
   assign unit_last = !cur_unit.is_repl || (sub_ff == REPL_LAST);
   assign job_last  = unit_last && ({1'b0, unit_idx_ff} == (job_count_ff - 3'd1));
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = job_valid_ff && rsp_free;

   assign req_chan.ready = !job_valid_ff || (emit && job_last);
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff      <= '0;
         need_ff      <= '0;
         count_ff     <= '0;
         job_valid_ff <= 1'b0;
         unit_idx_ff  <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            lead_ff  <= lead_in;
            need_ff  <= need_in;
            count_ff <= count_in;
         end
         if (accept && plan_n != '0) begin
            job_valid_ff <= 1'b1;
            unit_idx_ff  <= '0;
            sub_ff       <= '0;
         end else if (emit) begin
            if (job_last) begin
               job_valid_ff <= 1'b0;
            end else if (unit_last) begin
               unit_idx_ff <= unit_idx_ff + 2'd1;
               sub_ff      <= '0;
            end else begin
               sub_ff <= sub_ff + 3'd1;
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cont_we) begin
         cont_ff[count_ff[0]] <= b;
      end
      if (accept) begin
         job_units_ff <= plan_units;
         job_count_ff <= plan_n;
         job_end_ff   <= text_end;
      end
      if (emit) begin
         rsp_byte_ff     <= cur_byte;
         rsp_run_last_ff <= job_last;
         rsp_done_ff     <= job_last && job_end_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = rsp_byte_ff;
   assign rsp_chan.run_last  = rsp_run_last_ff;
   assign rsp_chan.text_done = rsp_done_ff;

endmodule

// ----- sv/utf8san_checker.sv -----
`timescale 1ns / 1ps
`include "utf8_stream_sanitizer_unit_macros.svh"

module utf8san_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input utf8san_pkg::byte_type out_byte,
   input logic                 run_last,
   input logic                 text_done
);
   import utf8san_pkg::*;

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   `U8S_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte) && $stable(run_last) && $stable(text_done) && $stable(req_take || 1'b1), "stalled item changed")

   `U8S_ASSERT_NXT(a_run_contiguous, clock, reset, rsp_take && !run_last, rsp_valid, "gap inside the results of one item")

   `U8S_ASSERT_NXT(a_repl_seq, clock, reset, rsp_take && !run_last && out_byte == REPL_BACKSLASH, out_byte == CHAR_LOWER_U, "replacement text broken after backslash")

   `U8S_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && req_ready, "not idle after reset")

endmodule

bind utf8_stream_sanitizer_unit utf8san_checker u_utf8san_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_byte  (rsp_chan.out_byte),
   .run_last  (rsp_chan.run_last),
   .text_done (rsp_chan.text_done)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import utf8san_pkg::*;

   typedef struct packed {
      byte_type value;
      logic     text_end;
      logic     drain_first;
   } text_item_type;

   typedef struct packed {
      byte_type out_byte;
      logic     run_last;
      logic     text_done;
   } clean_rec_type;

   localparam int RANDOM_ITEMS = 250;
   localparam int IDLE_PCT     = 12;

   logic clock = 1'b0;
   logic reset;

   utf8san_req_if req_bus ();
   utf8san_rsp_if rsp_bus ();

   utf8_stream_sanitizer_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   text_item_type text_q[$];
   clean_rec_type clean_q[$];
   byte_type      step_bytes[$];

   byte_type   seq_lead;
   byte_type   seq_cont[2];
   logic [1:0] seq_need;
   logic [1:0] seq_have;

   int            errors;
   int            items_taken;
   int            results_seen;
   int            items_total;
   logic          mark_drain;
   text_item_type next_item;
   clean_rec_type want;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void put_repl();
      step_bytes.push_back(REPL_BACKSLASH);
      step_bytes.push_back(CHAR_LOWER_U);
      step_bytes.push_back(CHAR_LOWER_F);
      step_bytes.push_back(CHAR_LOWER_F);
      step_bytes.push_back(CHAR_LOWER_F);
      step_bytes.push_back(CHAR_LOWER_D);
   endfunction

   function automatic void drop_seq();
      int i;
      put_repl();
      for (i = 0; i < int'(seq_have) && i < 2; i++) put_repl();
      seq_lead = '0;
      seq_need = '0;
      seq_have = '0;
   endfunction

   function automatic void take_fresh(byte_type b);
      if (b < ASCII_LIMIT) begin
         step_bytes.push_back(b);
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         seq_lead = b;
         seq_need = 2'd1;
         seq_have = '0;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         seq_lead = b;
         seq_need = 2'd2;
         seq_have = '0;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         seq_lead = b;
         seq_need = 2'd3;
         seq_have = '0;
      end else begin
         put_repl();
      end
   endfunction

   function automatic void sanitize_item(byte_type b, logic last);
      int i;
      int n;
      step_bytes.delete();
      if (seq_need != 0) begin
         if (b >= CONT_LO && b <= CONT_HI) begin
            if (int'(seq_have) + 1 >= int'(seq_need)) begin
               step_bytes.push_back(seq_lead);
               for (i = 0; i < int'(seq_have) && i < 2; i++) step_bytes.push_back(seq_cont[i]);
               step_bytes.push_back(b);
               seq_lead = '0;
               seq_need = '0;
               seq_have = '0;
            end else begin
               seq_cont[seq_have[0]] = b;
               seq_have = seq_have + 2'd1;
            end
         end else begin
            drop_seq();
            take_fresh(b);
         end
      end else begin
         take_fresh(b);
      end
      if (last && seq_need != 0) drop_seq();
      n = step_bytes.size();
      for (i = 0; i < n; i++) begin
         clean_q.push_back(clean_rec_type'{step_bytes[i], i == n - 1, last && (i == n - 1)});
      end
   endfunction

   function automatic void add_item(byte_type b, logic last);
      text_q.push_back(text_item_type'{b, last, mark_drain});
      mark_drain = 1'b0;
   endfunction

   function automatic byte_type pick_cont();
      return byte_type'($urandom_range(CONT_LO, CONT_HI));
   endfunction

   function automatic byte_type pick_lead(int conts);
      byte_type b;
      case (conts)
         1:       b = byte_type'($urandom_range(LEAD2_LO, LEAD2_HI));
         2:       b = byte_type'($urandom_range(LEAD3_LO, LEAD3_HI));
         default: b = byte_type'($urandom_range(LEAD4_LO, LEAD4_HI));
      endcase
      return b;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            sanitize_item(req_bus.in_byte, req_bus.text_end);
            items_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (text_q.size() == 0 || (text_q[0].drain_first && clean_q.size() != 0) ||
                (!(items_taken >= 120 && items_taken < 180) &&
                 $urandom_range(99) < IDLE_PCT)) begin
               req_bus.valid <= 1'b0;
            end else begin
               next_item = text_q.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.in_byte  <= next_item.value;
               req_bus.text_end <= next_item.text_end;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (clean_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual byte %02h last %b done %b",
                        $time, rsp_bus.out_byte, rsp_bus.run_last, rsp_bus.text_done);
               errors++;
            end else begin
               want = clean_q.pop_front();
               if (rsp_bus.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h, actual %02h",
                           $time, want.out_byte, rsp_bus.out_byte);
                  errors++;
               end
               if (rsp_bus.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %b, actual %b",
                           $time, want.run_last, rsp_bus.run_last);
                  errors++;
               end
               if (rsp_bus.text_done !== want.text_done) begin
                  $display("%0t: text_done expected %b, actual %b",
                           $time, want.text_done, rsp_bus.text_done);
                  errors++;
               end
            end
         end
         rsp_bus.ready <= (results_seen >= 200 && results_seen < 400) ||
                          ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      int       n;
      int       k;
      int       kind;
      int       conts;
      int       base_n;
      logic     mid_marked;
      byte_type text_buf[$];

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.in_byte  = 8'h01;
      req_bus.text_end = 1'b0;
      rsp_bus.ready    = 1'b0;
      errors           = 0;
      items_taken      = 0;
      results_seen     = 0;
      mark_drain       = 1'b0;
      mid_marked       = 1'b0;
      seq_lead         = '0;
      seq_cont[0]      = '0;
      seq_cont[1]      = '0;
      seq_need         = '0;
      seq_have         = '0;

      add_item(8'h01, 1'b0); add_item(8'h7F, 1'b0);
      add_item(8'hC2, 1'b0); add_item(8'h80, 1'b0);
      add_item(8'hDF, 1'b0); add_item(8'hBF, 1'b0);
      add_item(8'hE0, 1'b0); add_item(8'h80, 1'b0); add_item(8'h80, 1'b0);
      add_item(8'hF0, 1'b0); add_item(8'h80, 1'b0); add_item(8'h80, 1'b0);
      add_item(8'h80, 1'b0);
      add_item(8'hF4, 1'b0); add_item(8'hBF, 1'b0); add_item(8'hBF, 1'b0);
      add_item(8'hBF, 1'b1);
      add_item(8'h80, 1'b0); add_item(8'hFF, 1'b0); add_item(8'hC0, 1'b0);
      add_item(8'hE5, 1'b0); add_item(8'h41, 1'b0);
      add_item(8'hC3, 1'b0); add_item(8'hC3, 1'b0); add_item(8'hA9, 1'b0);
      add_item(8'hF0, 1'b0); add_item(8'h90, 1'b1);

      base_n     = text_q.size();
      mark_drain = 1'b1;
      while (text_q.size() < base_n + RANDOM_ITEMS) begin
         if (!mid_marked && text_q.size() >= base_n + RANDOM_ITEMS / 2) begin
            mark_drain = 1'b1;
            mid_marked = 1'b1;
         end
         text_buf.delete();
         n = $urandom_range(1, 10);
         for (k = 0; k < n; k++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
               text_buf.push_back(byte_type'($urandom_range(1, 8'h7F)));
            end else if (kind < 88) begin
               conts = (kind < 62) ? 1 : (kind < 76) ? 2 : 3;
               text_buf.push_back(pick_lead(conts));
               repeat (conts) text_buf.push_back(pick_cont());
            end else if (kind < 94) begin
               conts = $urandom_range(1, 3);
               text_buf.push_back(pick_lead(conts));
               repeat ($urandom_range(0, conts - 1)) text_buf.push_back(pick_cont());
            end else begin
               case ($urandom_range(2))
                  0:       text_buf.push_back(pick_cont());
                  1:       text_buf.push_back(byte_type'($urandom_range(8'hC0, 8'hC1)));
                  default: text_buf.push_back(byte_type'($urandom_range(8'hF5, 8'hFF)));
               endcase
            end
         end
         for (k = 0; k < text_buf.size(); k++) add_item(text_buf[k], k == text_buf.size() - 1);
      end
      items_total = text_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < items_total || clean_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/utf8san_pkg.sv
sv/utf8san_chan_if.sv
sv/utf8_stream_sanitizer_unit.sv
sv/utf8san_checker.sv
sim/tb.sv
